FILE: src/kidw_pkg.sv
// Package for the k-nearest-neighbor inverse-distance weighting block.
// Holds field widths, item kinds, arithmetic constants and the cell control struct.
// Depends on nothing.
package kidw_pkg;

    localparam int KIND_W     = 2;
    localparam int COORD_IN_W = 24;
    localparam int DEST_W     = 20;
    localparam int SRC_OUT_W  = 12;
    localparam int WEIGHT_W   = 17;
    localparam int CFG_W      = 4;

    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_APPEND = 2'd1;
    localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd2;

    localparam logic [CFG_W-1:0] K_RESET = 4'd5;

    localparam int SOURCE_DEPTH_DEF  = 4096;
    localparam int MAX_NEIGHBORS_DEF = 8;
    localparam int COORD_WIDTH_DEF   = 24;

    // Reciprocal is 2^40 / r, normalization numerator is inv * 2^16 + sum / 2.
    localparam int INV_SHIFT = 40;
    localparam int INV_W     = 41;
    localparam int SUM_W     = 46;
    localparam int NUM_W     = 58;
    localparam int FRAC_W    = 16;

    typedef struct packed {
        logic clear;
        logic cand_valid;
    } cell_ctl_t;

    // Equal share of the whole weight among z coincident neighbors, rounded.
    function automatic logic [WEIGHT_W-1:0] tie_weight(input logic [4:0] z);
        logic [WEIGHT_W-1:0] w;
        unique case (z)
            5'd1:    w = 17'd65536;
            5'd2:    w = 17'd32768;
            5'd3:    w = 17'd21845;
            5'd4:    w = 17'd16384;
            5'd5:    w = 17'd13107;
            5'd6:    w = 17'd10923;
            5'd7:    w = 17'd9362;
            5'd8:    w = 17'd8192;
            5'd9:    w = 17'd7282;
            5'd10:   w = 17'd6554;
            5'd11:   w = 17'd5958;
            5'd12:   w = 17'd5461;
            5'd13:   w = 17'd5041;
            5'd14:   w = 17'd4681;
            5'd15:   w = 17'd4369;
            5'd16:   w = 17'd4096;
            default: w = '0;
        endcase
        return w;
    endfunction

endpackage

FILE: src/kidw_cell.sv
// One cell of the sorted neighbor chain: holds a distance and a source index.
// Depends on kidw_pkg for the cell control struct.
module kidw_cell #(
    parameter int DIST_W = 52,
    parameter int IDX_W  = 12
) (
    input  logic                clk,
    input  logic                rst_n,
    input  kidw_pkg::cell_ctl_t ctl,
    input  logic                enable,
    input  logic [DIST_W-1:0]   cand_dist,
    input  logic [IDX_W-1:0]    cand_idx,
    input  logic                prev_take,
    input  logic                prev_valid,
    input  logic [DIST_W-1:0]   prev_dist,
    input  logic [IDX_W-1:0]    prev_idx,
    output logic                take,
    output logic                valid,
    output logic [DIST_W-1:0]   cur_dist,
    output logic [IDX_W-1:0]    idx
);

    logic              valid_reg, valid_next;
    logic [DIST_W-1:0] dist_reg, dist_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;

    // Strict compare: an equal distance stays ahead, so the lower index wins.
    assign take = enable && ctl.cand_valid && (!valid_reg || (cand_dist < dist_reg));

    always_comb
    begin
        valid_next = valid_reg;
        dist_next  = dist_reg;
        idx_next   = idx_reg;
        if (ctl.clear)
        begin
            valid_next = 1'b0;
        end
        else if (take)
        begin
            if (prev_take)
            begin
                valid_next = prev_valid;
                dist_next  = prev_dist;
                idx_next   = prev_idx;
            end
            else
            begin
                valid_next = 1'b1;
                dist_next  = cand_dist;
                idx_next   = cand_idx;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dist_reg <= dist_next;
        idx_reg  <= idx_next;
    end

    assign valid    = valid_reg;
    assign cur_dist = dist_reg;
    assign idx      = idx_reg;

endmodule

FILE: src/kidw_sqrt.sv
// Iterative integer square root, two radicand bits per cycle.
// Standalone; used by the top level for neighbor distances.
module kidw_sqrt #(
    parameter int IN_W = 52
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [IN_W-1:0]   radicand,
    output logic              done,
    output logic [IN_W/2-1:0] root
);

    localparam int RW  = IN_W / 2;
    localparam int CW  = $clog2(RW + 1);

    logic [IN_W-1:0] rad_reg, rad_next;
    logic [RW+1:0]   rem_reg, rem_next;
    logic [RW-1:0]   root_reg, root_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [RW+3:0]   rem_shift;
    logic [RW+3:0]   trial;

    assign rem_shift = {rem_reg, rad_reg[IN_W-1:IN_W-2]};
    assign trial     = {2'b00, root_reg, 2'b01};

    always_comb
    begin
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rad_next  = radicand;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rad_next = {rad_reg[IN_W-3:0], 2'b00};
            if (rem_shift >= trial)
            begin
                rem_next  = (RW+2)'(rem_shift - trial);
                root_next = {root_reg[RW-2:0], 1'b1};
            end
            else
            begin
                rem_next  = (RW+2)'(rem_shift);
                root_next = {root_reg[RW-2:0], 1'b0};
            end
            cnt_next = cnt_reg + CW'(1);
            if (cnt_reg == CW'(RW - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

FILE: src/kidw_div.sv
// Restoring divider, one quotient bit per cycle.
// Standalone; shared by the reciprocal and the weight normalization.
module kidw_div #(
    parameter int NUM_W = 58,
    parameter int DEN_W = 46
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] numer,
    input  logic [DEN_W-1:0] denom,
    output logic             done,
    output logic [NUM_W-1:0] quot
);

    localparam int CW = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] num_reg, num_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DEN_W:0]   rem_shift;
    logic             qbit;

    assign rem_shift = {rem_reg, num_reg[NUM_W-1]};
    assign qbit      = (rem_shift >= {1'b0, den_reg});

    always_comb
    begin
        num_next  = num_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            num_next  = numer;
            den_next  = denom;
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            num_next = {num_reg[NUM_W-2:0], qbit};
            if (qbit)
            begin
                rem_next = DEN_W'(rem_shift - {1'b0, den_reg});
            end
            else
            begin
                rem_next = DEN_W'(rem_shift);
            end
            cnt_next = cnt_reg + CW'(1);
            if (cnt_reg == CW'(NUM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
    end

    assign done = done_reg;
    assign quot = num_reg;

endmodule

FILE: src/knn_inverse_distance_weights.sv
// Top level of the k-nearest-neighbor inverse-distance weighting block.
// Depends on kidw_pkg, kidw_cell, kidw_sqrt and kidw_div.
//
// Usage:
// The input channel (in_valid/in_stall) carries one item per transaction: kind
// selects clear, append or query, with the point in coord_x/y/z. The output
// channel (out_valid/out_stall) returns one transaction per kept neighbor,
// ordered by distance, with last set on the final one; a query on an empty
// store returns a single transaction with status set. The configuration
// channel (cfg_valid/cfg_ready, always ready) sets the neighbor count; the user
// must write it only while the block is idle, as the block does not enforce it.
// A query scans the whole store through the distance pipeline into the chain
// of sorting cells, one source per cycle, then runs each kept neighbor through
// the shared square root and divider (two divisions per neighbor). If a kept
// neighbor lies at distance zero, these are skipped: the coincident neighbors
// share the weight equally and the others get zero. The next item is taken
// once the last result of a query is in the output register. A stall on the
// output holds that register, and the block waits to load its next result.
// Reset empties the store, zeroes the query counter and sets k to five; the
// source memory itself is not cleared.
module knn_inverse_distance_weights #(
    parameter int SOURCE_DEPTH  = kidw_pkg::SOURCE_DEPTH_DEF,
    parameter int MAX_NEIGHBORS = kidw_pkg::MAX_NEIGHBORS_DEF,
    parameter int COORD_WIDTH   = kidw_pkg::COORD_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [kidw_pkg::KIND_W-1:0]       kind,
    input  logic signed [kidw_pkg::COORD_IN_W-1:0] coord_x,
    input  logic signed [kidw_pkg::COORD_IN_W-1:0] coord_y,
    input  logic signed [kidw_pkg::COORD_IN_W-1:0] coord_z,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [kidw_pkg::CFG_W-1:0]        cfg_data,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [kidw_pkg::DEST_W-1:0]       dest_index,
    output logic [kidw_pkg::SRC_OUT_W-1:0]    source_index,
    output logic [kidw_pkg::WEIGHT_W-1:0]     weight,
    output logic                              status,
    output logic                              last
);

    localparam int AW     = (SOURCE_DEPTH > 1) ? $clog2(SOURCE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(SOURCE_DEPTH + 1);
    localparam int CW     = COORD_WIDTH;
    localparam int SQ_W   = 2 * CW + 2;
    localparam int DIST_W = 2 * CW + 4;
    localparam int RW     = DIST_W / 2;
    localparam int IW     = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
    localparam int HW     = $clog2(MAX_NEIGHBORS + 1);
    localparam int NUM_W  = kidw_pkg::NUM_W;
    localparam int SUM_W  = kidw_pkg::SUM_W;
    localparam int INV_W  = kidw_pkg::INV_W;
    localparam int WW     = kidw_pkg::WEIGHT_W;

    typedef enum logic [9:0] {
        S_IDLE   = 10'b0000000001,
        S_SCAN   = 10'b0000000010,
        S_TALLY  = 10'b0000000100,
        S_RSTART = 10'b0000001000,
        S_ROOT   = 10'b0000010000,
        S_RECIP  = 10'b0000100000,
        S_NSTART = 10'b0001000000,
        S_NORM   = 10'b0010000000,
        S_EMIT   = 10'b0100000000,
        S_ZEMIT  = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    // Source memory, x, y and z packed side by side.
    logic [3*CW-1:0] src_mem [SOURCE_DEPTH];
    logic [3*CW-1:0] rd_data_reg;

    logic [CNT_W-1:0] count_reg, count_next;
    logic [kidw_pkg::DEST_W-1:0] dest_reg, dest_next;
    logic [kidw_pkg::CFG_W-1:0]  k_cfg_reg;
    logic [HW-1:0]    k_eff_reg, k_eff_next, k_eff_c;

    logic signed [CW-1:0] qx_reg, qy_reg, qz_reg;
    logic [CNT_W-1:0] scan_cnt_reg, scan_cnt_next;
    logic             issue;
    logic             p1_valid_reg, p2_valid_reg;
    logic [AW-1:0]    p1_idx_reg, p2_idx_reg;
    logic [SQ_W-1:0]  sqx_reg, sqy_reg, sqz_reg;
    logic [DIST_W-1:0] cand_dist;

    logic [IW-1:0]    idx_reg, idx_next;
    logic [HW-1:0]    held_reg, held_next, held_c;
    logic [HW-1:0]    zeros_reg, zeros_next, zeros_c;
    logic [INV_W-1:0] inv_reg [MAX_NEIGHBORS];
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic [WW-1:0]    w_reg;
    logic             is_last;

    logic             out_valid_reg, out_valid_next;
    logic [kidw_pkg::DEST_W-1:0]    out_dest_reg;
    logic [kidw_pkg::SRC_OUT_W-1:0] out_src_reg;
    logic [WW-1:0]    out_weight_reg;
    logic             out_status_reg, out_last_reg;
    logic             out_free;
    logic             load_out;
    logic [kidw_pkg::SRC_OUT_W-1:0] load_src;
    logic [WW-1:0]    load_weight;
    logic             load_status;
    logic             load_last;

    logic             accept;
    logic             cell_clear;
    kidw_pkg::cell_ctl_t cell_ctl;
    logic             cell_take  [MAX_NEIGHBORS];
    logic             cell_valid [MAX_NEIGHBORS];
    logic [DIST_W-1:0] cell_dist [MAX_NEIGHBORS];
    logic [AW-1:0]    cell_idx   [MAX_NEIGHBORS];

    logic             sqrt_start, sqrt_done;
    logic [RW-1:0]    sqrt_root;
    logic             div_start, div_done;
    logic [NUM_W-1:0] div_num, div_quot;
    logic [SUM_W-1:0] div_den;
    logic             inv_write;

    // ---------------- handshakes ----------------
    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != S_IDLE) ||
                       ((kind == kidw_pkg::KIND_QUERY) && (count_reg == '0) && !out_free);
    assign accept    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        if (k_cfg_reg == '0)
        begin
            k_eff_c = HW'(1);
        end
        else if (int'(k_cfg_reg) > MAX_NEIGHBORS)
        begin
            k_eff_c = HW'(MAX_NEIGHBORS);
        end
        else
        begin
            k_eff_c = HW'(k_cfg_reg);
        end
    end

    // ---------------- source memory and distance pipeline ----------------
    assign issue = (state_reg == S_SCAN) && (scan_cnt_reg < count_reg);

    always_ff @(posedge clk)
    begin
        if (accept && (kind == kidw_pkg::KIND_APPEND) && (count_reg < CNT_W'(SOURCE_DEPTH)))
        begin
            src_mem[count_reg[AW-1:0]] <= {coord_x[CW-1:0], coord_y[CW-1:0], coord_z[CW-1:0]};
        end
        rd_data_reg <= src_mem[scan_cnt_reg[AW-1:0]];
    end

    function automatic logic [SQ_W-1:0] sq_diff(input logic signed [CW-1:0] a,
                                                input logic signed [CW-1:0] b);
        logic signed [CW:0] d;
        logic [CW:0]        m;
        d = CW'(0) + (CW+1)'(a) - (CW+1)'(b);
        m = d[CW] ? (CW+1)'(-d) : (CW+1)'(d);
        return SQ_W'(m) * SQ_W'(m);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
        end
        else
        begin
            p1_valid_reg <= issue;
            p2_valid_reg <= p1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        p1_idx_reg <= scan_cnt_reg[AW-1:0];
        p2_idx_reg <= p1_idx_reg;
        sqx_reg    <= sq_diff(rd_data_reg[3*CW-1:2*CW], qx_reg);
        sqy_reg    <= sq_diff(rd_data_reg[2*CW-1:CW], qy_reg);
        sqz_reg    <= sq_diff(rd_data_reg[CW-1:0], qz_reg);
        if (accept && (kind == kidw_pkg::KIND_QUERY))
        begin
            qx_reg <= coord_x[CW-1:0];
            qy_reg <= coord_y[CW-1:0];
            qz_reg <= coord_z[CW-1:0];
        end
    end

    assign cand_dist = DIST_W'(sqx_reg) + DIST_W'(sqy_reg) + DIST_W'(sqz_reg);

    // ---------------- chain of sorting cells ----------------
    assign cell_clear          = accept && (kind == kidw_pkg::KIND_QUERY);
    assign cell_ctl.clear      = cell_clear;
    assign cell_ctl.cand_valid = p2_valid_reg;

    generate
        for (genvar i = 0; i < MAX_NEIGHBORS; i++)
        begin : g_cell
            logic              prev_take;
            logic              prev_valid;
            logic [DIST_W-1:0] prev_dist;
            logic [AW-1:0]     prev_idx;
            if (i == 0)
            begin : g_head
                assign prev_take  = 1'b0;
                assign prev_valid = 1'b0;
                assign prev_dist  = '0;
                assign prev_idx   = '0;
            end
            else
            begin : g_body
                assign prev_take  = cell_take[i-1];
                assign prev_valid = cell_valid[i-1];
                assign prev_dist  = cell_dist[i-1];
                assign prev_idx   = cell_idx[i-1];
            end
            kidw_cell #(
                .DIST_W (DIST_W),
                .IDX_W  (AW)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctl        (cell_ctl),
                .enable     (HW'(i) < k_eff_reg),
                .cand_dist  (cand_dist),
                .cand_idx   (p2_idx_reg),
                .prev_take  (prev_take),
                .prev_valid (prev_valid),
                .prev_dist  (prev_dist),
                .prev_idx   (prev_idx),
                .take       (cell_take[i]),
                .valid      (cell_valid[i]),
                .cur_dist   (cell_dist[i]),
                .idx        (cell_idx[i])
            );
        end
    endgenerate

    always_comb
    begin
        held_c  = '0;
        zeros_c = '0;
        for (int i = 0; i < MAX_NEIGHBORS; i++)
        begin
            held_c  = held_c + HW'(cell_valid[i]);
            zeros_c = zeros_c + HW'(cell_valid[i] && (cell_dist[i] == '0));
        end
    end

    // ---------------- shared root and divider ----------------
    kidw_sqrt #(
        .IN_W (DIST_W)
    ) u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (cell_dist[idx_reg]),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    assign sqrt_start = (state_reg == S_RSTART);
    assign div_start  = ((state_reg == S_ROOT) && sqrt_done) || (state_reg == S_NSTART);

    always_comb
    begin
        if (state_reg == S_ROOT)
        begin
            div_num = NUM_W'(1) << kidw_pkg::INV_SHIFT;
            div_den = SUM_W'(sqrt_root);
        end
        else
        begin
            div_num = (NUM_W'(inv_reg[idx_reg]) << kidw_pkg::FRAC_W) + NUM_W'(sum_reg >> 1);
            div_den = sum_reg;
        end
    end

    kidw_div #(
        .NUM_W (NUM_W),
        .DEN_W (SUM_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .numer (div_num),
        .denom (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    assign inv_write = (state_reg == S_RECIP) && div_done;

    always_ff @(posedge clk)
    begin
        if (inv_write)
        begin
            inv_reg[idx_reg] <= div_quot[INV_W-1:0];
        end
        if ((state_reg == S_NORM) && div_done)
        begin
            w_reg <= div_quot[WW-1:0];
        end
    end

    // ---------------- sequencer ----------------
    assign is_last = ((HW'(idx_reg) + HW'(1)) == held_reg);

    always_comb
    begin
        logic [AW+kidw_pkg::SRC_OUT_W-1:0] idx_ext;
        idx_ext       = (AW+kidw_pkg::SRC_OUT_W)'(cell_idx[idx_reg]);
        state_next    = state_reg;
        count_next    = count_reg;
        dest_next     = dest_reg;
        k_eff_next    = k_eff_reg;
        scan_cnt_next = scan_cnt_reg;
        idx_next      = idx_reg;
        held_next     = held_reg;
        zeros_next    = zeros_reg;
        sum_next      = sum_reg;
        load_out      = 1'b0;
        load_src      = idx_ext[kidw_pkg::SRC_OUT_W-1:0];
        load_weight   = w_reg;
        load_status   = 1'b0;
        load_last     = is_last;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (kind)
                        kidw_pkg::KIND_CLEAR:
                        begin
                            count_next = '0;
                            dest_next  = '0;
                        end
                        kidw_pkg::KIND_APPEND:
                        begin
                            if (count_reg < CNT_W'(SOURCE_DEPTH))
                            begin
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        kidw_pkg::KIND_QUERY:
                        begin
                            if (count_reg == '0)
                            begin
                                load_out    = 1'b1;
                                load_src    = '0;
                                load_weight = '0;
                                load_status = 1'b1;
                                load_last   = 1'b1;
                                dest_next   = dest_reg + kidw_pkg::DEST_W'(1);
                            end
                            else
                            begin
                                k_eff_next    = k_eff_c;
                                scan_cnt_next = '0;
                                state_next    = S_SCAN;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (issue)
                begin
                    scan_cnt_next = scan_cnt_reg + CNT_W'(1);
                end
                else if (!p1_valid_reg && !p2_valid_reg)
                begin
                    state_next = S_TALLY;
                end
            end
            S_TALLY:
            begin
                held_next  = held_c;
                zeros_next = zeros_c;
                idx_next   = '0;
                sum_next   = '0;
                state_next = (zeros_c != '0) ? S_ZEMIT : S_RSTART;
            end
            S_RSTART:
            begin
                state_next = S_ROOT;
            end
            S_ROOT:
            begin
                if (sqrt_done)
                begin
                    state_next = S_RECIP;
                end
            end
            S_RECIP:
            begin
                if (div_done)
                begin
                    sum_next = sum_reg + SUM_W'(div_quot[INV_W-1:0]);
                    if (is_last)
                    begin
                        idx_next   = '0;
                        state_next = S_NSTART;
                    end
                    else
                    begin
                        idx_next   = idx_reg + IW'(1);
                        state_next = S_RSTART;
                    end
                end
            end
            S_NSTART:
            begin
                state_next = S_NORM;
            end
            S_NORM:
            begin
                if (div_done)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT, S_ZEMIT:
            begin
                if (state_reg == S_ZEMIT)
                begin
                    load_weight = (cell_dist[idx_reg] == '0) ?
                                  kidw_pkg::tie_weight(5'(zeros_reg)) : '0;
                end
                if (out_free)
                begin
                    load_out = 1'b1;
                    if (is_last)
                    begin
                        dest_next  = dest_reg + kidw_pkg::DEST_W'(1);
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + IW'(1);
                        state_next = (state_reg == S_ZEMIT) ? S_ZEMIT : S_NSTART;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && out_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            dest_reg      <= '0;
            k_cfg_reg     <= kidw_pkg::K_RESET;
            k_eff_reg     <= HW'(1);
            scan_cnt_reg  <= '0;
            idx_reg       <= '0;
            held_reg      <= '0;
            zeros_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            dest_reg      <= dest_next;
            k_eff_reg     <= k_eff_next;
            scan_cnt_reg  <= scan_cnt_next;
            idx_reg       <= idx_next;
            held_reg      <= held_next;
            zeros_reg     <= zeros_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                k_cfg_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg <= sum_next;
        if (load_out)
        begin
            out_dest_reg   <= dest_reg;
            out_src_reg    <= load_src;
            out_weight_reg <= load_weight;
            out_status_reg <= load_status;
            out_last_reg   <= load_last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign dest_index   = out_dest_reg;
    assign source_index = out_src_reg;
    assign weight       = out_weight_reg;
    assign status       = out_status_reg;
    assign last         = out_last_reg;

endmodule
